### rtl/link_quality_drop_monitor_unit_macros.svh
// assertion macros for the link quality drop monitor
// used by the top level; needs a clock named clock and a reset named reset in scope
`ifndef LINK_QUALITY_DROP_MONITOR_UNIT_MACROS_SVH
`define LINK_QUALITY_DROP_MONITOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LQDM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LQDM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lqdm_pkg.sv
// shared types, constants and helpers for the link quality drop monitor
// no dependencies
`default_nettype none

package lqdm_pkg;

   localparam int TimeWidth    = 48;
   localparam int RttWidth     = 16;
   localparam int LossWidth    = 8;
   localparam int PctWidth     = 7;
   localparam int RateWidth    = 32;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 32;
   localparam int ReqDataWidth = 136;
   localparam int RspDataWidth = 64;
   localparam int ReqUsedWidth = 134;
   localparam int RspUsedWidth = 59;

   // register reset values
   localparam logic [15:0] UpdatePeriodReset  = 16'd1000;
   localparam logic [6:0]  DropLossPctReset   = 7'd40;
   localparam logic [15:0] DropRttReset       = 16'd800;
   localparam logic [6:0]  RecoverLossReset   = 7'd30;
   localparam logic [15:0] RecoverRttReset    = 16'd500;
   localparam logic [15:0] RecoverHoldReset   = 16'd5000;
   localparam logic [31:0] VideoBitrateReset  = 32'd1000000;

   // register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_UPDATE_PERIOD = 3'd0,
      CSR_DROP_LOSS     = 3'd1,
      CSR_DROP_RTT      = 3'd2,
      CSR_RECOVER_LOSS  = 3'd3,
      CSR_RECOVER_RTT   = 3'd4,
      CSR_RECOVER_HOLD  = 3'd5,
      CSR_VIDEO_BITRATE = 3'd6
   } csr_index_type;

   // input beat, first field in the highest bits
   typedef struct packed {
      logic [RateWidth-1:0] audio_bitrate;
      logic                 audio_estimate_valid;
      logic [LossWidth-1:0] audio_loss;
      logic                 audio_loss_valid;
      logic [RttWidth-1:0]  audio_rtt_ms;
      logic                 audio_alive;
      logic [LossWidth-1:0] video_loss;
      logic                 video_loss_valid;
      logic [RttWidth-1:0]  video_rtt_ms;
      logic                 video_alive;
      logic                 video_present;
      logic [TimeWidth-1:0] now_ms;
   } req_beat_type;

   // result beat, first field in the highest bits
   typedef struct packed {
      logic [RateWidth-1:0] new_bitrate;
      logic                 new_bitrate_valid;
      logic                 drop_video;
      logic [LossWidth-1:0] smoothed_loss;
      logic [RttWidth-1:0]  smoothed_rtt;
      logic                 updated;
   } rsp_beat_type;

   // configuration as seen by the update logic
   typedef struct packed {
      logic [15:0]          update_period_ms;
      logic [PctWidth-1:0]  drop_loss_pct;
      logic [RttWidth-1:0]  drop_rtt_ms;
      logic [PctWidth-1:0]  recover_loss_pct;
      logic [RttWidth-1:0]  recover_rtt_ms;
      logic [15:0]          recover_hold_ms;
      logic [RateWidth-1:0] video_bitrate;
   } cfg_type;

   // floor(loss * 100 / 255) > pct  <=>  loss * 100 >= (pct + 1) * 255
   function automatic logic loss_pct_over(input logic [LossWidth-1:0] loss,
                                          input logic [PctWidth-1:0] pct);
      logic [15:0] scaled;
      logic [15:0] step;
      logic [15:0] limit;
      scaled = {8'd0, loss} * 16'd100;
      step   = {8'd0, 1'b0, pct} + 16'd1;
      limit  = {step[7:0], 8'd0} - step;
      return scaled >= limit;
   endfunction

endpackage

`default_nettype wire

### rtl/lqdm_update.sv
// quality update: smoothing, drop and restore decision, held link state
// depends on lqdm_pkg
`default_nettype none

module lqdm_update (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire lqdm_pkg::req_beat_type beat,
   input  wire lqdm_pkg::cfg_type      cfg,
   output lqdm_pkg::rsp_beat_type      result
);
   import lqdm_pkg::*;

   logic [TimeWidth-1:0] last_time_ff, last_time_in;
   logic [RttWidth-1:0]  rtt_mean_ff, rtt_mean_in;
   logic [LossWidth-1:0] loss_mean_ff, loss_mean_in;
   logic                 dropping_ff, dropping_in;
   logic [TimeWidth-1:0] recover_start_ff, recover_start_in;

   logic [TimeWidth-1:0] since_last;
   logic [TimeWidth-1:0] since_recover;
   logic                 do_update;
   logic                 have_rtt, use_video_loss, have_loss;
   logic [RttWidth-1:0]  rtt_sample;
   logic [LossWidth-1:0] loss_sample;
   logic [RttWidth:0]    rtt_sum;
   logic [LossWidth:0]   loss_sum;
   logic [RttWidth-1:0]  rtt_new;
   logic [LossWidth-1:0] loss_new;
   logic                 link_bad, drop_now, hold_done;
   logic [RateWidth-1:0] rate_cap;
   logic                 nb_valid;
   logic [RateWidth-1:0] nb;

   // elapsed times, modulo 2^48
   assign since_last    = beat.now_ms - last_time_ff;
   assign since_recover = beat.now_ms - recover_start_ff;
   assign do_update     = (last_time_ff == '0) ||
                          (since_last > {{(TimeWidth-16){1'b0}}, cfg.update_period_ms});

   // sample selection, video first then audio
   assign have_rtt       = beat.video_alive | beat.audio_alive;
   assign rtt_sample     = beat.video_alive ? beat.video_rtt_ms : beat.audio_rtt_ms;
   assign use_video_loss = beat.video_alive & beat.video_loss_valid;
   assign have_loss      = use_video_loss | (beat.audio_alive & beat.audio_loss_valid);
   assign loss_sample    = use_video_loss ? beat.video_loss : beat.audio_loss;

   // half-and-half running means
   assign rtt_sum  = {1'b0, rtt_mean_ff} + {1'b0, rtt_sample};
   assign loss_sum = {1'b0, loss_mean_ff} + {1'b0, loss_sample};
   assign rtt_new  = have_rtt ? rtt_sum[RttWidth:1] : rtt_mean_ff;
   assign loss_new = have_loss ? loss_sum[LossWidth:1] : loss_mean_ff;

   // threshold checks on the new means
   assign link_bad  = loss_pct_over(loss_new, cfg.recover_loss_pct) ||
                      (rtt_new > cfg.recover_rtt_ms);
   assign drop_now  = loss_pct_over(loss_new, cfg.drop_loss_pct) ||
                      (rtt_new > cfg.drop_rtt_ms);
   assign hold_done = since_recover > {{(TimeWidth-16){1'b0}}, cfg.recover_hold_ms};
   assign rate_cap  = cfg.video_bitrate >> 1;

   // next state and restore bitrate
   always_comb begin
      last_time_in     = last_time_ff;
      rtt_mean_in      = rtt_mean_ff;
      loss_mean_in     = loss_mean_ff;
      dropping_in      = dropping_ff;
      recover_start_in = recover_start_ff;
      nb_valid         = 1'b0;
      nb               = '0;
      if (do_update) begin
         last_time_in = beat.now_ms;
         rtt_mean_in  = rtt_new;
         loss_mean_in = loss_new;
         if (dropping_ff) begin
            if (link_bad) begin
               recover_start_in = '0;
            end else if (recover_start_ff == '0) begin
               recover_start_in = beat.now_ms;
            end else if (hold_done) begin
               dropping_in = 1'b0;
               if (beat.video_present && beat.audio_estimate_valid) begin
                  nb_valid = 1'b1;
                  nb       = (beat.audio_bitrate > rate_cap) ? rate_cap : beat.audio_bitrate;
               end
            end
         end else begin
            dropping_in      = drop_now;
            recover_start_in = '0;
         end
      end
   end

   // link state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff     <= '0;
         rtt_mean_ff      <= '0;
         loss_mean_ff     <= '0;
         dropping_ff      <= 1'b0;
         recover_start_ff <= '0;
      end else if (step_en) begin
         last_time_ff     <= last_time_in;
         rtt_mean_ff      <= rtt_mean_in;
         loss_mean_ff     <= loss_mean_in;
         dropping_ff      <= dropping_in;
         recover_start_ff <= recover_start_in;
      end
   end

   // result of this beat
   always_comb begin
      result.updated           = do_update;
      result.smoothed_rtt      = rtt_mean_in;
      result.smoothed_loss     = loss_mean_in;
      result.drop_video        = dropping_in;
      result.new_bitrate_valid = nb_valid;
      result.new_bitrate       = nb;
   end

endmodule

`default_nettype wire

### rtl/link_quality_drop_monitor_unit.sv
// top level of the link quality drop monitor: stream ports, registers, pipeline
// depends on lqdm_pkg, lqdm_update and link_quality_drop_monitor_unit_macros.svh
//
//   channel  | ports                       | payload
//   ---------+-----------------------------+------------------------------------
//   request  | req_tvalid/tready/tdata     | one time tick with session reports
//   response | rsp_tvalid/tready/tdata     | one quality result per tick
//   csr      | csr_wen/index/wdata         | seven period, hold, threshold and rate registers
//
// one tick a cycle while the response is not stalled; a tick is held in the input
// register and is then loaded into the result register, from which its result is
// offered. the input and result registers hold each tick in turn; the update
// logic between them is one pass.
// synchronous reset restores the register defaults and clears the link state.
// a stalled response holds the result; the input register still drains into
// it as soon as it is taken.
`default_nettype none
`include "link_quality_drop_monitor_unit_macros.svh"

module link_quality_drop_monitor_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: now_ms, video_present, video_alive, video_rtt_ms, video_loss_valid,
   // video_loss, audio_alive, audio_rtt_ms, audio_loss_valid, audio_loss,
   // audio_estimate_valid, audio_bitrate, zero pad
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [lqdm_pkg::ReqDataWidth-1:0] req_tdata,
   // response: updated, smoothed_rtt, smoothed_loss, drop_video,
   // new_bitrate_valid, new_bitrate, zero pad
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lqdm_pkg::RspDataWidth-1:0]      rsp_tdata,
   // register writes
   input  wire logic                              csr_wen,
   input  wire logic [lqdm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [lqdm_pkg::CsrDataWidth-1:0] csr_wdata
);
   import lqdm_pkg::*;

   cfg_type      cfg_ff;
   req_beat_type in_beat_ff;
   logic         in_valid_ff;
   rsp_beat_type out_beat_ff;
   logic         out_valid_ff;
   rsp_beat_type result;
   logic         advance;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.update_period_ms <= UpdatePeriodReset;
         cfg_ff.drop_loss_pct    <= DropLossPctReset;
         cfg_ff.drop_rtt_ms      <= DropRttReset;
         cfg_ff.recover_loss_pct <= RecoverLossReset;
         cfg_ff.recover_rtt_ms   <= RecoverRttReset;
         cfg_ff.recover_hold_ms  <= RecoverHoldReset;
         cfg_ff.video_bitrate    <= VideoBitrateReset;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_UPDATE_PERIOD: cfg_ff.update_period_ms <= csr_wdata[15:0];
            CSR_DROP_LOSS:     cfg_ff.drop_loss_pct    <= csr_wdata[PctWidth-1:0];
            CSR_DROP_RTT:      cfg_ff.drop_rtt_ms      <= csr_wdata[RttWidth-1:0];
            CSR_RECOVER_LOSS:  cfg_ff.recover_loss_pct <= csr_wdata[PctWidth-1:0];
            CSR_RECOVER_RTT:   cfg_ff.recover_rtt_ms   <= csr_wdata[RttWidth-1:0];
            CSR_RECOVER_HOLD:  cfg_ff.recover_hold_ms  <= csr_wdata[15:0];
            CSR_VIDEO_BITRATE: cfg_ff.video_bitrate    <= csr_wdata[RateWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_beat_ff <= req_beat_type'(req_tdata[ReqUsedWidth-1:0]);
      end
   end

   lqdm_update u_update (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .beat    (in_beat_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_beat_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-RspUsedWidth){1'b0}}, out_beat_ff};

   // checks
   `LQDM_ASSERT_NOW(a_restore_clears_drop, rsp_tvalid && out_beat_ff.new_bitrate_valid,
      !out_beat_ff.drop_video && out_beat_ff.updated, "restore beat still dropping")
   `LQDM_ASSERT_NOW(a_bitrate_zero_when_invalid,
      rsp_tvalid && !out_beat_ff.new_bitrate_valid,
      out_beat_ff.new_bitrate == '0, "bitrate set without a restore")
   `LQDM_ASSERT_NOW(a_ready_when_empty, !out_valid_ff, req_tready,
      "input stalled with an empty result register")
   `LQDM_ASSERT_NEXT(a_tick_reaches_result, advance, out_valid_ff,
      "tick lost between the registers")

endmodule

`default_nettype wire
